@@ src/assert_macros.svh @@
// Assertion macros shared by the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/u16u8_pkg.sv @@
// Types, constants and encoding helpers for the UTF-16LE to UTF-8 transcoder.
package u16u8_pkg;

  // Surrogate ranges
  localparam logic [15:0] HI_SUR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SUR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SUR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SUR_LAST  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // Default depth of the job queue between front and back
  localparam int JOB_Q_DEPTH = 2;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // One queued job: an optional flushed high surrogate, then an optional code point
  typedef struct packed {
    logic        has_lead;
    logic [9:0]  lead_bits;
    logic [20:0] cp;
    logic [2:0]  cp_len;   // 0 when there is no code point
  } job_t;

  // Number of UTF-8 bytes for a code point
  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < 21'h80) begin
      len = 3'd1;
    end else if (cp < 21'h800) begin
      len = 3'd2;
    end else if (cp < SUPP_BASE) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte number idx of the UTF-8 encoding of cp, whose length is len
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = {2'b10, cp[5:0]};
    endcase
    return b;
  endfunction

endpackage

@@ src/u16u8_front.sv @@
// Front end: accepts code units, pairs surrogates and builds byte-run jobs.
`include "assert_macros.svh"

module u16u8_front
  import u16u8_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     job_push_o,
  output job_t     job_o
);

  logic       held_q, held_d;
  logic [9:0] lead_q, lead_d;
  logic       accept;
  logic       is_hi, is_lo;
  logic       keep_new;
  logic [20:0] pair_cp;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  // Classify the incoming unit
  assign is_hi = (in_item_i.code_unit >= HI_SUR_FIRST) && (in_item_i.code_unit <= HI_SUR_LAST);
  assign is_lo = (in_item_i.code_unit >= LO_SUR_FIRST) && (in_item_i.code_unit <= LO_SUR_LAST);
  assign keep_new = is_hi && !in_item_i.last_unit;
  assign pair_cp  = {1'b0, lead_q, in_item_i.code_unit[9:0]} + SUPP_BASE;

  // Job building and held-surrogate update
  always_comb begin
    held_d     = held_q;
    lead_d     = lead_q;
    job_o      = '0;
    job_push_o = 1'b0;
    if (accept) begin
      if (held_q && is_lo) begin
        held_d       = 1'b0;
        job_o.cp     = pair_cp;
        job_o.cp_len = 3'd4;
        job_push_o   = 1'b1;
      end else begin
        job_o.has_lead  = held_q;
        job_o.lead_bits = lead_q;
        if (keep_new) begin
          held_d = 1'b1;
          lead_d = in_item_i.code_unit[9:0];
        end else begin
          held_d       = 1'b0;
          job_o.cp     = {5'b0, in_item_i.code_unit};
          job_o.cp_len = utf8_len({5'b0, in_item_i.code_unit});
        end
        job_push_o = held_q || !keep_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      lead_q <= '0;
    end else begin
      held_q <= held_d;
      lead_q <= lead_d;
    end
  end

  // A final unit never leaves a surrogate held
  `ASSERT_NEXT(a_last_flushes, clk_i, rst_ni, accept && in_item_i.last_unit, !held_q)

endmodule

@@ src/u16u8_fifo.sv @@
// Short job queue between the front end and the byte emitter.
`include "assert_macros.svh"

module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int Depth = JOB_Q_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output job_t rd_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en, rd_en;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign wr_en     = wr_i && !full_o;
  assign rd_en     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (rd_en) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(Depth))
  `ASSERT_NEXT(a_cnt_grows, clk_i, rst_ni, wr_en && !rd_en, cnt_q == $past(cnt_q) + 1'b1)

endmodule

@@ src/u16u8_back.sv @@
// Back end: walks each job byte by byte into the result register.
`include "assert_macros.svh"

module u16u8_back
  import u16u8_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  job_t      q_data_i,
  output logic      q_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  job_t       job_q, job_d;
  logic       job_valid_q, job_valid_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic [2:0]  lead_len, run_len, idx2;
  logic        in_lead, at_end, advance;
  logic [20:0] lead_cp;
  logic [7:0]  cur_byte;

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;
  assign advance    = !out_valid_q || pop;

  // Position within the current run
  assign lead_len = job_q.has_lead ? 3'd3 : 3'd0;
  assign run_len  = lead_len + job_q.cp_len;
  assign in_lead  = job_q.has_lead && (idx_q < 3'd3);
  assign idx2     = idx_q - lead_len;
  assign at_end   = (idx_q == run_len - 3'd1);
  assign lead_cp  = 21'(HI_SUR_FIRST) | 21'(job_q.lead_bits);
  assign cur_byte = in_lead ? utf8_byte(lead_cp, 3'd3, idx_q[1:0])
                            : utf8_byte(job_q.cp, job_q.cp_len, idx2[1:0]);

  // One byte per cycle on advance; reload from the queue at run end
  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;
    q_pop_o     = 1'b0;
    if (advance && job_valid_q) begin
      out_d.out_byte = cur_byte;
      out_d.run_last = at_end;
      out_valid_d    = 1'b1;
      idx_d          = idx_q + 3'd1;
    end
    if (!job_valid_q || (advance && at_end)) begin
      q_pop_o     = !q_empty_i;
      job_valid_d = !q_empty_i;
      job_d       = q_data_i;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ASSERT_IMPL(a_run_nonzero, clk_i, rst_ni, job_valid_q, run_len != 3'd0)
  `ASSERT_IMPL(a_idx_in_run, clk_i, rst_ni, job_valid_q, idx_q < run_len)

endmodule

@@ src/utf16le_to_utf8_transcoder_top.sv @@
// Top level of the UTF-16LE to UTF-8 transcoder.
// Takes one UTF-16 code unit per item and delivers its UTF-8 bytes one per result, with
// run_last on the final byte an item causes. A high surrogate that is not the final unit
// is held and yields nothing until the next item; a following low surrogate completes a
// four-byte sequence, anything else flushes the held surrogate as three bytes first. The
// result side carries one byte per cycle while the result register is empty or popped; an
// item yields 0 to 4 bytes, and up to 6 when a held surrogate is flushed. Input is taken
// every cycle while the job queue (JobQDepth entries) has room; the first byte of an item
// passes through the queue, then the job register and the result register of the emitter.
module utf16le_to_utf8_transcoder_top
  import u16u8_pkg::*;
#(
  parameter int JobQDepth = JOB_Q_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic q_full, q_empty, q_pop, job_push;
  job_t job_in, job_out;

  u16u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  u16u8_fifo #(
    .Depth (JobQDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_push),
    .wr_data_i (job_in),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .empty_o   (q_empty),
    .rd_data_o (job_out)
  );

  u16u8_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (job_out),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule
